>>> rtl/core/thm_pkg.sv
// shared types, codes and reset constants of the heartbeat monitor
package thm_pkg;

	// widths
	localparam int TIME_BITS = 32;
	localparam int NTASK     = 3;
	localparam int TAG_W     = 8;
	localparam int CFG_IDX_W = 3;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TAG_W-1:0]     tag_t;
	typedef logic [1:0]           task_idx_t;
	typedef logic [1:0]           func_code_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// event kinds
	localparam func_code_t FUNC_MARK  = 2'd0;
	localparam func_code_t FUNC_ENTER = 2'd1;
	localparam func_code_t FUNC_LEAVE = 2'd2;
	localparam func_code_t FUNC_CHECK = 2'd3;

	// task index that names no task
	localparam task_idx_t TASK_NONE = 2'd3;

	// scan positions
	localparam task_idx_t TASK_0 = 2'd0;
	localparam task_idx_t TASK_1 = 2'd1;
	localparam task_idx_t TASK_2 = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_PERIOD_T0 = 3'd0;
	localparam cfg_idx_t REG_GUARD_T0  = 3'd1;
	localparam cfg_idx_t REG_PERIOD_T1 = 3'd2;
	localparam cfg_idx_t REG_GUARD_T1  = 3'd3;
	localparam cfg_idx_t REG_PERIOD_T2 = 3'd4;
	localparam cfg_idx_t REG_GUARD_T2  = 3'd5;

	// limit reset values
	localparam time_t PERIOD_RESET [NTASK] = '{32'd2000, 32'd1000, 32'd0};
	localparam time_t GUARD_RESET  [NTASK] = '{32'd2000, 32'd3000, 32'd2000};

	// controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      apply;
		logic      scan;
		task_idx_t scan_idx;
	} thm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_check;
	} thm_sts_t;

endpackage

>>> rtl/core/thm_ctrl.sv
// sequencing state machine of the heartbeat monitor
module thm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  thm_pkg::thm_sts_t sts,
	output thm_pkg::thm_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import thm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN0,
		ST_SCAN1,
		ST_SCAN2
	} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_SCAN2);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= sts.in_check ? ST_SCAN0 : ST_APPLY;
					end
				end
				ST_APPLY: state_q <= ST_IDLE;
				ST_SCAN0: state_q <= ST_SCAN1;
				ST_SCAN1: state_q <= ST_SCAN2;
				ST_SCAN2: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = start && (state_q == ST_IDLE);
		cmd.apply    = (state_q == ST_APPLY);
		cmd.scan_idx = TASK_0;
		case (state_q)
			ST_SCAN0: begin
				cmd.scan     = 1'b1;
				cmd.scan_idx = TASK_0;
			end
			ST_SCAN1: begin
				cmd.scan     = 1'b1;
				cmd.scan_idx = TASK_1;
			end
			ST_SCAN2: begin
				cmd.scan     = 1'b1;
				cmd.scan_idx = TASK_2;
			end
			default: begin
				cmd.scan = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

>>> rtl/core/thm_dp.sv
// task state, limit registers, age evaluation and stall verdict
module thm_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  thm_pkg::thm_cmd_t     cmd,
	output thm_pkg::thm_sts_t     sts,
	input  logic                  cfg_we,
	input  thm_pkg::cfg_idx_t     cfg_index,
	input  thm_pkg::time_t        cfg_data,
	input  thm_pkg::func_code_t   func,
	input  thm_pkg::task_idx_t    task_req,
	input  thm_pkg::time_t        now_ms,
	input  thm_pkg::tag_t         op_tag,
	output logic                  feed,
	output logic                  stalled,
	output thm_pkg::task_idx_t    stall_task,
	output thm_pkg::time_t        stall_age_ms,
	output logic                  stall_busy,
	output thm_pkg::tag_t         stall_op_tag
);
	import thm_pkg::*;

	// captured event
	func_code_t func_q;
	task_idx_t  task_q;
	time_t      now_q;
	tag_t       tag_q;

	// limits
	time_t period_q [NTASK];
	time_t guard_q  [NTASK];

	// per task state
	time_t alive_q    [NTASK];
	time_t op_start_q [NTASK];
	logic  busy_q     [NTASK];
	tag_t  cur_tag_q  [NTASK];
	logic  started_q  [NTASK];

	// verdict
	logic      vd_latched_q;
	task_idx_t vd_task_q;
	time_t     vd_age_q;
	logic      vd_busy_q;
	tag_t      vd_tag_q;

	// age evaluation of the scanned task
	logic  sc_busy;
	time_t sc_diff;
	time_t sc_limit;
	logic  sc_stale;

	assign sts.in_check = (func == FUNC_CHECK);

	// input capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			task_q <= task_req;
			now_q  <= now_ms;
			tag_q  <= op_tag;
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTASK; i++) begin
				period_q[i] <= PERIOD_RESET[i];
				guard_q[i]  <= GUARD_RESET[i];
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD_T0: period_q[0] <= cfg_data;
				REG_GUARD_T0:  guard_q[0]  <= cfg_data;
				REG_PERIOD_T1: period_q[1] <= cfg_data;
				REG_GUARD_T1:  guard_q[1]  <= cfg_data;
				REG_PERIOD_T2: period_q[2] <= cfg_data;
				REG_GUARD_T2:  guard_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// event update of the named task; task none changes nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTASK; i++) begin
				alive_q[i]    <= '0;
				op_start_q[i] <= '0;
				busy_q[i]     <= 1'b0;
				cur_tag_q[i]  <= '0;
				started_q[i]  <= 1'b0;
			end
		end else if (cmd.apply && (task_q != TASK_NONE)) begin
			case (func_q)
				FUNC_MARK: begin
					alive_q[task_q]   <= now_q;
					started_q[task_q] <= 1'b1;
				end
				FUNC_ENTER: begin
					op_start_q[task_q] <= now_q;
					cur_tag_q[task_q]  <= tag_q;
					busy_q[task_q]     <= 1'b1;
					started_q[task_q]  <= 1'b1;
				end
				FUNC_LEAVE: begin
					busy_q[task_q]  <= 1'b0;
					alive_q[task_q] <= now_q;
				end
				default: ;
			endcase
		end
	end

	// wrapping age against the active limit; zero age stays fresh
	always_comb begin
		sc_busy  = busy_q[cmd.scan_idx];
		sc_diff  = sc_busy ? (now_q - op_start_q[cmd.scan_idx])
		                   : (now_q - alive_q[cmd.scan_idx]);
		sc_limit = sc_busy ? guard_q[cmd.scan_idx] : period_q[cmd.scan_idx];
		sc_stale = started_q[cmd.scan_idx]
		           && (sc_busy || (period_q[cmd.scan_idx] != '0))
		           && (sc_diff >= sc_limit)
		           && (sc_diff != '0);
	end

	// first stale task latches the verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_latched_q <= 1'b0;
			vd_task_q    <= TASK_NONE;
			vd_age_q     <= '0;
			vd_busy_q    <= 1'b0;
			vd_tag_q     <= '0;
		end else if (cmd.scan && !vd_latched_q && sc_stale) begin
			vd_latched_q <= 1'b1;
			vd_task_q    <= cmd.scan_idx;
			vd_age_q     <= sc_diff;
			vd_busy_q    <= sc_busy;
			vd_tag_q     <= sc_busy ? cur_tag_q[cmd.scan_idx] : '0;
		end
	end

	assign feed         = !vd_latched_q;
	assign stalled      = vd_latched_q;
	assign stall_task   = vd_task_q;
	assign stall_age_ms = vd_age_q;
	assign stall_busy   = vd_busy_q;
	assign stall_op_tag = vd_tag_q;

endmodule

>>> rtl/core/task_heartbeat_monitor_core.sv
// top level of the three-task heartbeat monitor
//
// Command channel: an event (func, task_req, now_ms, op_tag) transfers at a
// rising edge with start high and busy low. Mark, enter and leave update the
// named task in the cycle after the transfer and give no result; task 3 is
// ignored. A check scans tasks 0, 1 and 2, one per cycle through a single
// subtract and compare unit, and the result appears for exactly one cycle
// with done high, registered from the scan of task 2. busy is low again in
// that result cycle, so the next event can transfer while a result is shown;
// no new event is taken while busy is high.
// The receiver cannot stall: a result is taken in the cycle done is high.
// The result ports hold the verdict registers; feed falls and stays low once
// a stale task has been found, until reset.
// Configuration: cfg_valid/cfg_ready write limit register cfg_index with
// cfg_data; cfg_ready is always high and indexes above 5 are dropped. Write
// only while busy is low and no result is pending.
// Reset (arst_n low) clears all task state and the verdict and loads the
// default limits; no clearing pass is needed.
module task_heartbeat_monitor_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  thm_pkg::func_code_t func,
	input  thm_pkg::task_idx_t  task_req,
	input  thm_pkg::time_t      now_ms,
	input  thm_pkg::tag_t       op_tag,
	output logic                done,
	output logic                feed,
	output logic                stalled,
	output thm_pkg::task_idx_t  stall_task,
	output thm_pkg::time_t      stall_age_ms,
	output logic                stall_busy,
	output thm_pkg::tag_t       stall_op_tag,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  thm_pkg::cfg_idx_t   cfg_index,
	input  thm_pkg::time_t      cfg_data
);
	import thm_pkg::*;

	thm_cmd_t cmd;
	thm_sts_t sts;
	logic     start_ok;

	assign cfg_ready = 1'b1;
	assign start_ok  = start && !busy;

	// controller
	thm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath
	thm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.task_req     (task_req),
		.now_ms       (now_ms),
		.op_tag       (op_tag),
		.feed         (feed),
		.stalled      (stalled),
		.stall_task   (stall_task),
		.stall_age_ms (stall_age_ms),
		.stall_busy   (stall_busy),
		.stall_op_tag (stall_op_tag)
	);

	// a check transfer is followed by its result with done high
	a_check_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start_ok && (func == FUNC_CHECK)) |-> ##4 done)
		else $error("check result not delivered on time");

	// result strobe is a single cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// verdict stays latched until reset
	a_stall_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stalled |=> stalled)
		else $error("stall verdict cleared without reset");

	// a latched verdict names a real task
	a_stall_task: assert property (@(posedge clk) disable iff (!arst_n)
		stalled |-> (stall_task != TASK_NONE))
		else $error("stall verdict without a task");

endmodule
